>>> sv/skst_pkg.sv
// ----------------------------------------------------------------------------
// skst_pkg
// Shared types and constants for the sorted key set table: command and
// status codes, request and response words, and per-cell control.
// ----------------------------------------------------------------------------
package skst_pkg;

   localparam int CAPACITY    = 64;
   localparam int KEY_WIDTH   = 48;
   localparam int INDEX_WIDTH = $clog2(CAPACITY);
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [KEY_WIDTH-1:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [INDEX_WIDTH-1:0] index;
      logic [COUNT_WIDTH-1:0] count;
   } rsp_type;

   typedef struct packed {
      logic                 load;
      logic                 shift_up;
      logic                 shift_down;
      logic [KEY_WIDTH-1:0] key;
   } cell_ctrl_type;

   typedef struct packed {
      logic                   hit;
      logic [INDEX_WIDTH-1:0] pos;
   } locate_type;

endpackage

>>> sv/skst_cell.sv
// ----------------------------------------------------------------------------
// skst_cell
// One slot of the sorted row: holds a key, compares it with the command key
// and moves keys to or from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module skst_cell (
   input  logic                           clock,
   input  skst_pkg::cell_ctrl_type        ctrl,
   input  logic                           occupied,
   input  logic                           lt_prev,
   input  logic [skst_pkg::KEY_WIDTH-1:0] key_prev,
   input  logic [skst_pkg::KEY_WIDTH-1:0] key_next,
   output logic [skst_pkg::KEY_WIDTH-1:0] key_out,
   output logic                           lt_out,
   output logic                           eq_out
);

   logic [skst_pkg::KEY_WIDTH-1:0] key_ff;
   logic [skst_pkg::KEY_WIDTH-1:0] key_in;
   logic                           lt_ff;
   logic                           lt_in;
   logic                           eq_ff;
   logic                           eq_in;

   always_comb begin
      key_in = key_ff;
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      if (ctrl.load) begin
         lt_in = occupied && (key_ff < ctrl.key);
         eq_in = occupied && (key_ff == ctrl.key);
      end
      if (ctrl.shift_up && !lt_ff) begin
         key_in = lt_prev ? ctrl.key : key_prev;
      end else if (ctrl.shift_down && !lt_ff) begin
         key_in = key_next;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key_out = key_ff;
   assign lt_out  = lt_ff;
   assign eq_out  = eq_ff;

endmodule

>>> sv/skst_locate.sv
// ----------------------------------------------------------------------------
// skst_locate
// Turns the row's less-than and equal flags into the sorted position of the
// command key and a hit flag.
// ----------------------------------------------------------------------------
module skst_locate (
   input  logic [skst_pkg::CAPACITY-1:0] lt,
   input  logic [skst_pkg::CAPACITY-1:0] eq,
   output skst_pkg::locate_type          result
);

   logic [skst_pkg::CAPACITY-1:0] boundary;

   always_comb begin
      result.hit = |eq;
      result.pos = '0;
      for (int i = 0; i < skst_pkg::CAPACITY; i++) begin
         if (i == 0) begin
            boundary[i] = !lt[i];
         end else begin
            boundary[i] = lt[i-1] && !lt[i];
         end
         if (boundary[i]) begin
            result.pos = result.pos | skst_pkg::INDEX_WIDTH'(i);
         end
      end
   end

endmodule

>>> sv/sorted_key_set_table.sv
// ----------------------------------------------------------------------------
// sorted_key_set_table
// Set of unique keys kept in ascending order in a row of cells that compare
// in parallel and shift one place on insert or remove.
// ----------------------------------------------------------------------------
// commands: the row compares the key at the accepting edge, then the locate
//   and shift step registers the response word and raises the result strobe
// a new command is taken only once the compare and shift steps of the cell
//   row are done; busy is high for the one cycle between them
// reset: entry count zero, key storage contents left as they are
// the receiver cannot stall: the response strobe is high for one cycle per word
module sorted_key_set_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  skst_pkg::req_type req_word,
   output logic              rsp_strobe,
   output skst_pkg::rsp_type rsp_word
);

   localparam int N = skst_pkg::CAPACITY;

   logic                             busy_ff;
   logic                             busy_in;
   logic [1:0]                       cmd_ff;
   logic [1:0]                       cmd_in;
   logic [skst_pkg::KEY_WIDTH-1:0]   key_ff;
   logic [skst_pkg::KEY_WIDTH-1:0]   key_in;
   logic [skst_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [skst_pkg::COUNT_WIDTH-1:0] count_in;
   logic                             rsp_strobe_ff;
   logic                             rsp_strobe_in;
   skst_pkg::rsp_type                rsp_word_ff;
   skst_pkg::rsp_type                rsp_word_in;

   logic                             accept;
   logic                             full;
   skst_pkg::cell_ctrl_type          ctrl;
   skst_pkg::locate_type             loc;
   logic [N-1:0]                     lt;
   logic [N-1:0]                     eq;
   logic [N-1:0]                     occupied;
   logic [skst_pkg::KEY_WIDTH-1:0]   keys [N];

   assign accept = start && !busy_ff;
   assign full   = (count_ff == skst_pkg::COUNT_WIDTH'(N));

   always_comb begin
      ctrl.load       = accept;
      ctrl.key        = key_ff;
      ctrl.shift_up   = busy_ff && (cmd_ff == skst_pkg::CMD_INSERT) && !loc.hit && !full;
      ctrl.shift_down = busy_ff && (cmd_ff == skst_pkg::CMD_REMOVE) && loc.hit;
      if (accept) begin
         ctrl.key = req_word.key;
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_row
      logic [skst_pkg::KEY_WIDTH-1:0] key_prev;
      logic [skst_pkg::KEY_WIDTH-1:0] key_next;
      logic                           lt_prev;

      assign occupied[g] = (skst_pkg::COUNT_WIDTH'(g) < count_ff);

      if (g == 0) begin : g_first
         assign key_prev = key_ff;
         assign lt_prev  = 1'b1;
      end else begin : g_mid
         assign key_prev = keys[g-1];
         assign lt_prev  = lt[g-1];
      end

      if (g == N - 1) begin : g_last
         assign key_next = keys[g];
      end else begin : g_inner
         assign key_next = keys[g+1];
      end

      skst_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .occupied (occupied[g]),
         .lt_prev  (lt_prev),
         .key_prev (key_prev),
         .key_next (key_next),
         .key_out  (keys[g]),
         .lt_out   (lt[g]),
         .eq_out   (eq[g])
      );
   end

   skst_locate u_locate (
      .lt     (lt),
      .eq     (eq),
      .result (loc)
   );

   always_comb begin
      busy_in       = busy_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      if (accept) begin
         busy_in = 1'b1;
         cmd_in  = req_word.cmd;
         key_in  = req_word.key;
      end
      if (busy_ff) begin
         busy_in            = 1'b0;
         rsp_strobe_in      = 1'b1;
         rsp_word_in.status = skst_pkg::STATUS_OK;
         rsp_word_in.index  = '0;
         unique case (cmd_ff)
            skst_pkg::CMD_INSERT: begin
               if (loc.hit) begin
                  rsp_word_in.status = skst_pkg::STATUS_MISS;
                  rsp_word_in.index  = loc.pos;
               end else if (full) begin
                  rsp_word_in.status = skst_pkg::STATUS_FULL;
               end else begin
                  rsp_word_in.index = loc.pos;
                  count_in          = count_ff + skst_pkg::COUNT_WIDTH'(1);
               end
            end
            skst_pkg::CMD_REMOVE: begin
               if (loc.hit) begin
                  rsp_word_in.index = loc.pos;
                  count_in          = count_ff - skst_pkg::COUNT_WIDTH'(1);
               end else begin
                  rsp_word_in.status = skst_pkg::STATUS_MISS;
               end
            end
            skst_pkg::CMD_LOOKUP: begin
               if (loc.hit) begin
                  rsp_word_in.index = loc.pos;
               end else begin
                  rsp_word_in.status = skst_pkg::STATUS_MISS;
               end
            end
            skst_pkg::CMD_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
         rsp_word_in.count = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

>>> sim/sorted_key_set_table_monitor.sv
// ----------------------------------------------------------------------------
// sorted_key_set_table_monitor
// Watches the command and response channels of the sorted key set table. It
// keeps a shadow copy of the ordered key set, works out the response to each
// accepted command and compares every response word field by field against
// the oldest one still due.
// ----------------------------------------------------------------------------
module sorted_key_set_table_monitor
   import skst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_word,
   input  logic    rsp_strobe,
   input  rsp_type rsp_word,
   output int      fail_count,
   output int      pending_count,
   output int      result_count,
   output int      full_count,
   output int      miss_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [KEY_WIDTH-1:0] shadow_keys [CAPACITY];
   int                   shadow_count;
   rsp_type              rsp_due [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      result_count  = 0;
      full_count    = 0;
      miss_count    = 0;
      shadow_count  = 0;
   end

   function automatic rsp_type apply_command(req_type cmd_word);
      rsp_type res = '0;
      int      pos = 0;
      logic    hit;
      while (pos < shadow_count && shadow_keys[pos] < cmd_word.key) pos++;
      hit = (pos < shadow_count) && (shadow_keys[pos] == cmd_word.key);
      res.status = STATUS_OK;
      case (cmd_word.cmd)
         CMD_INSERT: begin
            if (hit) begin
               res.status = STATUS_MISS;
               res.index  = pos[INDEX_WIDTH-1:0];
            end else if (shadow_count >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               for (int i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
               shadow_keys[pos] = cmd_word.key;
               shadow_count++;
               res.index = pos[INDEX_WIDTH-1:0];
            end
         end
         CMD_REMOVE: begin
            if (hit) begin
               for (int i = pos; i < shadow_count - 1; i++) shadow_keys[i] = shadow_keys[i+1];
               shadow_count--;
               res.index = pos[INDEX_WIDTH-1:0];
            end else begin
               res.status = STATUS_MISS;
            end
         end
         CMD_LOOKUP: begin
            if (hit) res.index = pos[INDEX_WIDTH-1:0];
            else res.status = STATUS_MISS;
         end
         default: begin
            shadow_count = 0;
         end
      endcase
      res.count = shadow_count[COUNT_WIDTH-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         shadow_count = 0;
         rsp_due.delete();
      end else begin
         if (rsp_strobe) begin
            result_count++;
            if (rsp_word.status == STATUS_FULL) full_count++;
            if (rsp_word.status == STATUS_MISS) miss_count++;
            if (rsp_due.size() == 0) begin
               $error("response word with none due: status %0d index %0d count %0d",
                      rsp_word.status, rsp_word.index, rsp_word.count);
               fail_count++;
            end else begin
               due = rsp_due.pop_front();
               if (rsp_word.status !== due.status) begin
                  $error("status mismatch: expected %0d, got %0d", due.status, rsp_word.status);
                  fail_count++;
               end
               if (rsp_word.index !== due.index) begin
                  $error("index mismatch: expected %0d, got %0d", due.index, rsp_word.index);
                  fail_count++;
               end
               if (rsp_word.count !== due.count) begin
                  $error("count mismatch: expected %0d, got %0d", due.count, rsp_word.count);
                  fail_count++;
               end
            end
         end
         if (start && !busy) rsp_due.push_back(apply_command(req_word));
      end
      pending_count = rsp_due.size();
   end

endmodule

>>> sim/sorted_key_set_table_test.sv
// ----------------------------------------------------------------------------
// sorted_key_set_table_test
// Drives the sorted key set table with a short directed run over the key
// extremes and every command, then with random fill, drain and mixed phases
// over a small key pool so the set fills up, empties and hits duplicates and
// misses. The monitor predicts and checks; this module gives the verdict.
// ----------------------------------------------------------------------------
module sorted_key_set_table_test;
   import skst_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_type;

   localparam int POOL_SIZE    = 96;
   localparam int RANDOM_WORDS = 1600;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_strobe;
   rsp_type rsp_word;

   int fail_count;
   int pending_count;
   int result_count;
   int full_count;
   int miss_count;

   logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];
   int                   words_sent;

   sorted_key_set_table dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   sorted_key_set_table_monitor table_monitor (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_word      (req_word),
      .rsp_strobe    (rsp_strobe),
      .rsp_word      (rsp_word),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count),
      .full_count    (full_count),
      .miss_count    (miss_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [KEY_WIDTH-1:0] random_key();
      logic [63:0] wide;
      wide = {$urandom(), $urandom()};
      return wide[KEY_WIDTH-1:0];
   endfunction

   function automatic int pick_gap(bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // word stays up across back-to-back commands, lowered only for a gap
   task automatic send_word(input logic [1:0] cmd, input logic [KEY_WIDTH-1:0] key,
                            input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_word.cmd <= cmd;
      req_word.key <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_now(input logic [1:0] cmd, input logic [KEY_WIDTH-1:0] key);
      send_word(cmd, key, pick_gap(1'b0));
   endtask

   function automatic logic [1:0] pick_cmd(phase_type phase);
      int roll;
      roll = $urandom_range(0, 99);
      case (phase)
         PHASE_FILL: begin
            if (roll < 70) return CMD_INSERT;
            if (roll < 80) return CMD_REMOVE;
            if (roll < 99) return CMD_LOOKUP;
            return CMD_CLEAR;
         end
         PHASE_DRAIN: begin
            if (roll < 60) return CMD_REMOVE;
            if (roll < 78) return CMD_INSERT;
            if (roll < 99) return CMD_LOOKUP;
            return CMD_CLEAR;
         end
         default: begin
            if (roll < 35) return CMD_INSERT;
            if (roll < 60) return CMD_REMOVE;
            if (roll < 98) return CMD_LOOKUP;
            return CMD_CLEAR;
         end
      endcase
   endfunction

   initial begin
      logic [KEY_WIDTH-1:0] top_key;
      logic [KEY_WIDTH-1:0] mid_key;
      logic [KEY_WIDTH-1:0] key;
      phase_type            phase;
      int                   phase_len;
      int                   random_sent;
      bit                   quiet;
      int                   drain_wait;

      reset      <= 1'b1;
      start      <= 1'b0;
      req_word   <= '0;
      words_sent = 0;
      top_key    = '1;
      mid_key    = {1'b1, {(KEY_WIDTH-1){1'b0}}};

      key_pool[0] = '0;
      key_pool[1] = top_key;
      key_pool[2] = KEY_WIDTH'(1);
      key_pool[3] = top_key - KEY_WIDTH'(1);
      key_pool[4] = mid_key;
      key_pool[5] = mid_key - KEY_WIDTH'(1);
      for (int i = 6; i < POOL_SIZE; i++) key_pool[i] = random_key();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty set, key extremes, duplicate, misses, clear
      send_now(CMD_LOOKUP, mid_key);
      send_now(CMD_REMOVE, mid_key);
      send_now(CMD_INSERT, top_key);
      send_now(CMD_INSERT, '0);
      send_now(CMD_INSERT, mid_key);
      send_now(CMD_INSERT, mid_key);
      send_now(CMD_INSERT, KEY_WIDTH'(1));
      send_now(CMD_INSERT, top_key - KEY_WIDTH'(1));
      send_now(CMD_LOOKUP, '0);
      send_now(CMD_LOOKUP, top_key);
      send_now(CMD_LOOKUP, KEY_WIDTH'(1));
      send_now(CMD_LOOKUP, KEY_WIDTH'(2));
      send_now(CMD_REMOVE, mid_key);
      send_now(CMD_REMOVE, mid_key);
      send_now(CMD_REMOVE, top_key);
      send_now(CMD_REMOVE, '0);
      send_now(CMD_INSERT, '0);
      send_now(CMD_CLEAR, top_key);
      send_now(CMD_LOOKUP, KEY_WIDTH'(1));
      send_now(CMD_REMOVE, KEY_WIDTH'(1));
      send_now(CMD_CLEAR, '0);
      send_now(CMD_INSERT, mid_key - KEY_WIDTH'(1));

      // random phases over the key pool
      random_sent = 0;
      while (random_sent < RANDOM_WORDS) begin
         phase     = phase_type'($urandom_range(0, 2));
         phase_len = $urandom_range(40, 200);
         quiet     = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < phase_len && random_sent < RANDOM_WORDS; n++) begin
            if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else key = random_key();
            send_word(pick_cmd(phase), key, pick_gap(quiet));
            random_sent++;
         end
      end

      start <= 1'b0;
      drain_wait = 0;
      while (pending_count != 0 && drain_wait < 200) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (10) @(posedge clock);

      $display("sent %0d command words, checked %0d response words", words_sent, result_count);
      $display("store-full refusals seen: %0d, duplicates or misses seen: %0d",
               full_count, miss_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (pending_count != 0) $error("%0d response words never arrived", pending_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> sorted_key_set_table.f
sv/skst_pkg.sv
sv/skst_cell.sv
sv/skst_locate.sv
sv/sorted_key_set_table.sv
sim/sorted_key_set_table_monitor.sv
sim/sorted_key_set_table_test.sv
